### src/sbs_pkg.sv
// Shared types, sequencer states and the key function for the stable byte sorter.
package sbs_pkg;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SORT,
    ST_DRAIN
  } state_e;

  localparam logic MODE_FOLD = 1'b0;

  // Per-cell control, driven by the sequencer in the top level.
  typedef struct packed {
    logic load;       // take the incoming byte
    logic shift;      // take the right neighbor's byte (drain toward cell 0)
    logic cmp_right;  // this cell is the left member of a compare pair
    logic cmp_left;   // this cell is the right member of a compare pair
  } cell_ctl_t;

  // Comparison key: optional A-Z to a-z fold, then read as a signed byte.
  function automatic logic signed [7:0] sort_key(input logic [7:0] b, input logic mode);
    logic [7:0] v;
    v = b;
    if (mode == MODE_FOLD && (b inside {[8'h41:8'h5A]})) begin
      v = b + 8'h20;
    end
    return $signed(v);
  endfunction

endpackage

### src/stable_byte_sorter.sv
// Top level of the stable byte sorter: cell chain and its sequencer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  input   | in        | in_valid_i / in_stall_o | byte_in_i, last_in_i
//  output  | out       | out_valid_o/ out_stall_i| sorted_byte_o, last_out_o, overflow_o
//  config  | in        | cfg_we_i                | cfg_wdata_i (order_mode)
//
// A list of kept bytes is collected one byte per cycle, sorted by odd-even transposition
// across the cell chain, and drained one byte per cycle in which the output is not
// stalled. The sort length is set by the byte count: each round compares either the
// even or the odd neighboring pairs, and n alternating rounds order n bytes.
// Reset clears the sequencer, the byte count, the overflow flag and the mode; the cell
// contents are not reset, since only cells below the count are ever read.
// The input is stalled while a list is being sorted or drained. A stalled output holds
// cell 0 unchanged, and the whole chain waits with it.
module stable_byte_sorter
  import sbs_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] sorted_byte_o,
  output logic       last_out_o,
  output logic       overflow_o
);

  localparam int CW = $clog2(MAX_LEN + 1);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   round_q, round_d;
  logic            ovf_q, ovf_d;
  logic            mode_q;
  logic            in_req;
  logic            out_req;
  logic            sorting;
  logic            collecting;
  logic            full;
  logic [7:0]      cell_data [MAX_LEN];
  cell_ctl_t       cell_ctl  [MAX_LEN];

  // The order mode is sampled by the cells at compare time, so a change between
  // lists takes effect at the next sort.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FOLD;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // State-dependent handshake outputs.
  always_comb begin
    collecting  = 1'b0;
    sorting     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_COLLECT: collecting  = 1'b1;
      ST_SORT:    sorting     = 1'b1;
      ST_DRAIN:   out_valid_o = 1'b1;
      default:    collecting  = 1'b0;
    endcase
  end

  assign in_stall_o = !collecting;
  assign in_req     = in_valid_i && collecting;
  assign out_req    = out_valid_o && !out_stall_i;
  assign full       = (count_q == CW'(MAX_LEN));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_req && last_in_i) begin
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        if (round_q == count_q - CW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_req && (count_q == CW'(1))) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Count, overflow and sort round bookkeeping.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    round_d = round_q;
    if (in_req) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
      round_d = '0;
    end
    if (sorting) begin
      round_d = round_q + CW'(1);
    end
    if (out_req) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1)) begin
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      count_q <= '0;
      round_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      round_q <= round_d;
      ovf_q   <= ovf_d;
    end
  end

  // The chain. Even rounds pair cells (0,1), (2,3) and so on; odd rounds pair
  // (1,2), (3,4) and so on. Only cells below the count take part.
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [7:0] left_data;
    logic [7:0] right_data;
    logic       is_pair_left;

    assign is_pair_left = (1'(i % 2) == round_q[0]);

    if (i == 0) begin : g_first
      assign left_data = 8'h00;
      assign cell_ctl[i].cmp_left = 1'b0;
    end else begin : g_inner
      assign left_data = cell_data[i-1];
      assign cell_ctl[i].cmp_left = sorting && !is_pair_left && (count_q > CW'(i));
    end

    if (i == MAX_LEN - 1) begin : g_final
      assign right_data = 8'h00;
      assign cell_ctl[i].cmp_right = 1'b0;
    end else begin : g_body
      assign right_data = cell_data[i+1];
      assign cell_ctl[i].cmp_right = sorting && is_pair_left && (count_q > CW'(i + 1));
    end

    assign cell_ctl[i].load  = in_req && (count_q == CW'(i));
    assign cell_ctl[i].shift = out_req;

    sbs_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[i]),
      .mode_i  (mode_q),
      .byte_i  (byte_in_i),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[i])
    );
  end

  // Cell 0 always holds the next byte to go out.
  assign sorted_byte_o = cell_data[0];
  assign last_out_o    = (count_q == CW'(1));
  assign overflow_o    = ovf_q;

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_q != '0))
    else $error("drain with an empty chain");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LEN))
    else $error("byte count beyond capacity");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |-> (round_q < count_q))
    else $error("sort round beyond list length");

  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req && last_out_o) |=> (count_q == '0) && !ovf_q && (state_q == ST_COLLECT))
    else $error("state not cleared after final byte");

  a_drain_from_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_SORT))
    else $error("drain started without a sort");

endmodule

### src/sbs_cell.sv
// One storage cell of the sorter chain: load, shift left, or compare-exchange.
module sbs_cell
  import sbs_pkg::*;
(
  input  logic            clk_i,
  input  cell_ctl_t       ctl_i,
  input  logic            mode_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      left_i,
  input  logic [7:0]      right_i,
  output logic [7:0]      data_o
);

  logic [7:0]        data_q;
  logic [7:0]        data_d;
  logic signed [7:0] key_own;
  logic signed [7:0] key_left;
  logic signed [7:0] key_right;

  assign key_own   = sort_key(data_q, mode_i);
  assign key_left  = sort_key(left_i, mode_i);
  assign key_right = sort_key(right_i, mode_i);

  // Exchanges happen only on a strictly larger left key, which keeps equal keys in order.
  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = byte_i;
    end else if (ctl_i.shift) begin
      data_d = right_i;
    end else if (ctl_i.cmp_right && (key_own > key_right)) begin
      data_d = right_i;
    end else if (ctl_i.cmp_left && (key_left > key_own)) begin
      data_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### verif/tb.sv
// Testbench for the stable byte sorter: list stimulus, sort prediction and result checks.
`timescale 1ns / 1ps

// Keeps the lists that have been sent and the sorted results still owed by the block.
class sort_scoreboard;
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       overflow;
  } sorted_entry_t;

  logic          order_mode;
  int            capacity;
  int            errors;
  logic [7:0]    held[$];
  logic          dropped;
  sorted_entry_t expected[$];

  function new(int cap);
    capacity   = cap;
    order_mode = sbs_pkg::MODE_FOLD;
    errors     = 0;
    dropped    = 1'b0;
  endfunction

  // Case folding touches the comparison only; the byte itself is returned raw.
  function logic signed [7:0] key_of(logic [7:0] b);
    logic [7:0] k;
    k = b;
    if (order_mode == sbs_pkg::MODE_FOLD && b >= 8'h41 && b <= 8'h5A) begin
      k = b | 8'h20;
    end
    return $signed(k);
  endfunction

  function void note_request(logic [7:0] b, logic l);
    logic [7:0]    ordered[$];
    sorted_entry_t e;
    int            j;
    if (held.size() < capacity) begin
      held.push_back(b);
    end else begin
      dropped = 1'b1;
    end
    if (!l) return;
    // An element only moves ahead of strictly larger keys, which keeps the sort stable.
    foreach (held[i]) begin
      j = ordered.size();
      while (j > 0 && key_of(ordered[j-1]) > key_of(held[i])) j--;
      ordered.insert(j, held[i]);
    end
    foreach (ordered[i]) begin
      e.value    = ordered[i];
      e.last     = (i == ordered.size() - 1);
      e.overflow = dropped;
      expected.push_back(e);
    end
    held.delete();
    dropped = 1'b0;
  endfunction

  function void check_result(logic [7:0] b, logic l, logic o);
    sorted_entry_t want;
    if (expected.size() == 0) begin
      $display("%0t: sorted byte expected none, got %h (last %b, overflow %b)",
               $time, b, l, o);
      errors++;
      return;
    end
    want = expected.pop_front();
    if (b !== want.value) begin
      $display("%0t: sorted byte expected %h, got %h", $time, want.value, b);
      errors++;
    end
    if (l !== want.last) begin
      $display("%0t: last flag expected %b, got %b", $time, want.last, l);
      errors++;
    end
    if (o !== want.overflow) begin
      $display("%0t: overflow flag expected %b, got %b", $time, want.overflow, o);
      errors++;
    end
  endfunction

  function bit idle();
    return expected.size() == 0;
  endfunction
endclass

module tb
  import sbs_pkg::*;
();

  // The list capacity of the block; lists beyond it lose bytes and raise overflow.
  localparam int LIST_CAP = 64;
  // Plain signed byte order, the other setting of the mode register.
  localparam logic MODE_RAW = 1'b1;
  // Cycles without any accepted request before the run is declared hung. The
  // slowest legal stretch is a long receiver hold-off on top of a full sort.
  localparam int STALL_LIMIT = 3000;
  // Length of the single long receiver hold-off, in cycles.
  localparam int LONG_HOLD = 600;

  // Directed lists, first byte in the top bits. The letter mix places each case
  // pair and the characters just outside A-Z and a-z next to each other.
  localparam logic [63:0] LETTER_MIX = {8'h61, 8'h41, 8'h5A, 8'h7A,
                                        8'h40, 8'h5B, 8'h60, 8'h7B};
  // Signed extremes: 0x80 must sort first and 0x7F last.
  localparam logic [63:0] EXTREMES = {8'h7F, 8'h80, 8'hFF, 8'h00, 8'h01, 24'h0};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] byte_in_i   = 8'h00;
  logic       last_in_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] sorted_byte_o;
  logic       last_out_o;
  logic       overflow_o;

  // Idling switches for each side, and the one-shot long hold-off request.
  bit tx_idle      = 1'b1;
  bit rx_idle      = 1'b1;
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  sort_scoreboard sb = new(LIST_CAP);

  stable_byte_sorter #(
    .MAX_LEN(LIST_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sorted_byte_o(sorted_byte_o),
    .last_out_o   (last_out_o),
    .overflow_o   (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  // Offers one byte and returns on the rising edge at which the block takes it.
  // A random gap may come first; the valid is lowered for the gap only, so a
  // stream of back-to-back requests keeps it high without a glitch.
  task automatic send_request(input logic [7:0] b, input logic l);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    last_in_i  <= l;
    // Outputs are read at the edge itself, before the block's registers move.
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(b, l);
  endtask

  // Sends a directed list of up to eight bytes packed first-byte-high.
  task automatic send_packed_list(input logic [63:0] bytes, input int len);
    for (int i = 0; i < len; i++) begin
      send_request(bytes[63 - 8*i -: 8], i == len - 1);
    end
  endtask

  // Letter-heavy lists stress case folding and stability; the others use the
  // whole byte range so that every bit of the data takes both values.
  task automatic send_random_list(input int len, input bit letters);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (letters && $urandom_range(0, 3) != 0) begin
        b = 8'($urandom_range(8'h3F, 8'h7C));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_request(b, i == len - 1);
    end
  endtask

  // Mostly short lists, now and then a longer one, until the budget is spent.
  task automatic run_random_phase(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      send_random_list(len, $urandom_range(0, 1));
      sent += len;
    end
  endtask

  // The mode is only changed with no list in flight: the valid drops, every
  // owed result must have come out, and a settling wait follows before the write.
  task automatic set_order_mode(input logic m);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (!sb.idle()) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    sb.order_mode = m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: alternates runs of readiness with stall bursts, and once serves
  // a long hold-off so that the block fills up and has to stall its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  // Every accepted result is checked against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(sorted_byte_o, last_out_o, overflow_o);
    end
  end

  // Watchdog on progress: any accepted request on either channel restarts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lists in folded order: a single byte, the letter boundaries with
    // equal keys of both cases, and the signed extremes.
    set_order_mode(MODE_FOLD);
    send_packed_list({8'h41, 56'h0}, 1);
    send_packed_list(LETTER_MIX, 8);
    send_packed_list(EXTREMES, 5);

    // The same letters in plain order, where upper case sorts ahead.
    set_order_mode(MODE_RAW);
    send_packed_list(LETTER_MIX, 8);

    // A list that exactly fills the block while the receiver holds off, then
    // one that overflows by a single byte, so the flagged last byte is dropped.
    set_order_mode(MODE_FOLD);
    hold_off_req = 1'b1;
    send_random_list(LIST_CAP, 1'b1);
    send_random_list(LIST_CAP + 1, 1'b0);

    set_order_mode(MODE_RAW);
    run_random_phase(8);
    set_order_mode(MODE_FOLD);
    run_random_phase(8);

    // Closing stretch at full rate on both sides.
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_order_mode(MODE_RAW);
    run_random_phase(8);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (!sb.idle()) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (sb.idle() && sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
